FILE: hw/rtl/md5_pkg.sv
// ----------------------------------------------------------------------------
// MD5 digest package
// Word types, microcode encoding, round constants and the control store.
// ----------------------------------------------------------------------------
package md5_pkg;

  typedef struct packed {
    logic       cmd;
    logic [7:0] data_byte;
  } md5_in_t;

  typedef struct packed {
    logic [7:0] digest_byte;
    logic [3:0] byte_index;
    logic       last_of_digest;
  } md5_out_t;

  localparam logic CMD_APPEND = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  typedef logic [3:0] upc_t;

  localparam upc_t PC_WAIT   = 4'd0;
  localparam upc_t PC_PAD80  = 4'd1;
  localparam upc_t PC_PADCHK = 4'd2;
  localparam upc_t PC_PADZ   = 4'd3;
  localparam upc_t PC_LENLO  = 4'd4;
  localparam upc_t PC_LENHI  = 4'd5;
  localparam upc_t PC_ROUND  = 4'd6;
  localparam upc_t PC_ADD    = 4'd7;
  localparam upc_t PC_EMIT   = 4'd8;
  localparam upc_t PC_INIT   = 4'd9;

  typedef enum logic [3:0] {
    OP_WAIT,
    OP_PAD80,
    OP_NOP,
    OP_ZERO,
    OP_LENLO,
    OP_LENHI,
    OP_ROUND,
    OP_ADD,
    OP_EMIT,
    OP_INIT
  } op_e;

  typedef enum logic [2:0] {
    C_NEXT,
    C_WAIT,
    C_POS63,
    C_POS56,
    C_ALWAYS,
    C_RND_LAST,
    C_RETURN,
    C_EMIT_LAST
  } cond_e;

  typedef struct packed {
    op_e   op;
    cond_e cond;
    upc_t  jmp;
    upc_t  nxt;
    logic  set_ret;
    upc_t  ret;
  } ctrl_t;

  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hefcdab89;
  localparam logic [31:0] IV_C = 32'h98badcfe;
  localparam logic [31:0] IV_D = 32'h10325476;

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] POS_LAST = 6'd63;
  localparam logic [5:0] POS_LEN  = 6'd56;
  localparam logic [3:0] WORD_LENLO = 4'd14;
  localparam logic [3:0] WORD_LENHI = 4'd15;

  localparam logic [31:0] K_TAB [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam logic [4:0] ROT_TAB [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9,  5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
  };

  function automatic logic [3:0] msg_idx(logic [5:0] rnd);
    logic [3:0] i;
    logic [3:0] g;
    i = rnd[3:0];
    case (rnd[5:4])
      2'd0:    g = i;
      2'd1:    g = 4'((i << 2) + i + 4'd1);
      2'd2:    g = 4'((i << 1) + i + 4'd5);
      default: g = 4'((i << 3) - i);
    endcase
    return g;
  endfunction

  function automatic ctrl_t ucode(upc_t pc);
    ctrl_t cw;
    cw = '{op: OP_NOP, cond: C_NEXT, jmp: PC_WAIT, nxt: PC_WAIT, set_ret: 1'b0,
           ret: PC_WAIT};
    case (pc)
      PC_WAIT:   cw = '{OP_WAIT,  C_WAIT,      PC_ROUND,  PC_PAD80,  1'b1, PC_WAIT};
      PC_PAD80:  cw = '{OP_PAD80, C_POS63,     PC_ROUND,  PC_PADCHK, 1'b1, PC_PADCHK};
      PC_PADCHK: cw = '{OP_NOP,   C_POS56,     PC_LENLO,  PC_PADZ,   1'b0, PC_WAIT};
      PC_PADZ:   cw = '{OP_ZERO,  C_POS63,     PC_ROUND,  PC_PADCHK, 1'b1, PC_PADCHK};
      PC_LENLO:  cw = '{OP_LENLO, C_NEXT,      PC_WAIT,   PC_LENHI,  1'b0, PC_WAIT};
      PC_LENHI:  cw = '{OP_LENHI, C_ALWAYS,    PC_ROUND,  PC_WAIT,   1'b1, PC_EMIT};
      PC_ROUND:  cw = '{OP_ROUND, C_RND_LAST,  PC_ADD,    PC_ROUND,  1'b0, PC_WAIT};
      PC_ADD:    cw = '{OP_ADD,   C_RETURN,    PC_WAIT,   PC_WAIT,   1'b0, PC_WAIT};
      PC_EMIT:   cw = '{OP_EMIT,  C_EMIT_LAST, PC_INIT,   PC_EMIT,   1'b0, PC_WAIT};
      PC_INIT:   cw = '{OP_INIT,  C_ALWAYS,    PC_WAIT,   PC_WAIT,   1'b0, PC_WAIT};
      default:   cw = '{OP_NOP,   C_ALWAYS,    PC_WAIT,   PC_WAIT,   1'b0, PC_WAIT};
    endcase
    return cw;
  endfunction

endpackage

FILE: hw/rtl/md5_message_digest.sv
// ----------------------------------------------------------------------------
// Append word: stores one byte; a word that fills a block starts a compression.
// Finish word: pads with 0x80 and zero bytes, appends the bit length (in an extra
// block when it spills) and compresses; then 16 output words follow.
// Reset (async, low): chaining words to the MD5 IV, counters to zero.
// ----------------------------------------------------------------------------
module md5_message_digest (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  md5_pkg::md5_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output md5_pkg::md5_out_t out_data_o
);

  md5_pkg::upc_t  pc_q, pc_d, ret_q, ret_d;
  md5_pkg::ctrl_t cw;
  logic [5:0]     rnd_q, rnd_d;
  logic [5:0]     pos_q, pos_d;
  logic [3:0]     k_q, k_d;
  logic [63:0]    count_q, count_d;
  logic [31:0]    chain_q [4];
  logic [31:0]    chain_d [4];
  logic [31:0]    a_q, b_q, c_q, d_q;
  logic [31:0]    blk_q [16];

  logic        in_acc, out_acc, taken, load_abcd;
  logic        byte_we;
  logic [7:0]  byte_wd;
  logic [31:0] f, m, sum, rot;
  logic [63:0] rot_wide;
  logic [4:0]  s;
  logic [31:0] sel_word;

  assign cw      = md5_pkg::ucode(pc_q);
  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  assign in_ready_o  = (pc_q == md5_pkg::PC_WAIT);
  assign out_valid_o = (pc_q == md5_pkg::PC_EMIT);

  assign sel_word               = chain_q[k_q[3:2]];
  assign out_data_o.digest_byte = sel_word[{k_q[1:0], 3'b000} +: 8];
  assign out_data_o.byte_index  = k_q;
  assign out_data_o.last_of_digest = (k_q == 4'd15);

  always_comb begin
    case (cw.cond)
      md5_pkg::C_WAIT:      taken = in_acc && (in_data_i.cmd == md5_pkg::CMD_APPEND)
                                    && (pos_q == md5_pkg::POS_LAST);
      md5_pkg::C_POS63:     taken = (pos_q == md5_pkg::POS_LAST);
      md5_pkg::C_POS56:     taken = (pos_q == md5_pkg::POS_LEN);
      md5_pkg::C_ALWAYS:    taken = 1'b1;
      md5_pkg::C_RND_LAST:  taken = (rnd_q == 6'd63);
      md5_pkg::C_EMIT_LAST: taken = out_acc && (k_q == 4'd15);
      default:              taken = 1'b0;
    endcase
  end

  always_comb begin
    ret_d = ret_q;
    if (cw.cond == md5_pkg::C_RETURN) begin
      pc_d = ret_q;
    end else if (taken) begin
      pc_d = cw.jmp;
      if (cw.set_ret) ret_d = cw.ret;
    end else if (cw.cond == md5_pkg::C_WAIT) begin
      // hold until a finish word arrives
      pc_d = (in_acc && (in_data_i.cmd == md5_pkg::CMD_FINISH)) ? cw.nxt : pc_q;
    end else begin
      pc_d = cw.nxt;
    end
  end

  assign load_abcd = taken && (cw.jmp == md5_pkg::PC_ROUND) && (pc_q != md5_pkg::PC_ROUND);

  always_comb begin
    case (rnd_q[5:4])
      2'd0:    f = (b_q & c_q) | (~b_q & d_q);
      2'd1:    f = (b_q & d_q) | (c_q & ~d_q);
      2'd2:    f = b_q ^ c_q ^ d_q;
      default: f = c_q ^ (b_q | ~d_q);
    endcase
  end

  assign m        = blk_q[md5_pkg::msg_idx(rnd_q)];
  assign s        = md5_pkg::ROT_TAB[{rnd_q[5:4], rnd_q[1:0]}];
  assign sum      = a_q + f + m + md5_pkg::K_TAB[rnd_q];
  assign rot_wide = {sum, sum} << s;
  assign rot      = rot_wide[63:32];

  always_comb begin
    rnd_d   = rnd_q;
    pos_d   = pos_q;
    k_d     = k_q;
    count_d = count_q;
    chain_d = chain_q;
    byte_we = 1'b0;
    byte_wd = in_data_i.data_byte;
    case (cw.op)
      md5_pkg::OP_WAIT: begin
        if (in_acc && (in_data_i.cmd == md5_pkg::CMD_APPEND)) begin
          byte_we = 1'b1;
          pos_d   = pos_q + 6'd1;
          count_d = count_q + 64'd8;
        end
      end
      md5_pkg::OP_PAD80: begin
        byte_we = 1'b1;
        byte_wd = md5_pkg::PAD_BYTE;
        pos_d   = pos_q + 6'd1;
      end
      md5_pkg::OP_ZERO: begin
        byte_we = 1'b1;
        byte_wd = 8'h00;
        pos_d   = pos_q + 6'd1;
      end
      md5_pkg::OP_ROUND: rnd_d = rnd_q + 6'd1;
      md5_pkg::OP_ADD: begin
        chain_d[0] = chain_q[0] + a_q;
        chain_d[1] = chain_q[1] + b_q;
        chain_d[2] = chain_q[2] + c_q;
        chain_d[3] = chain_q[3] + d_q;
      end
      md5_pkg::OP_EMIT: begin
        if (out_acc) k_d = k_q + 4'd1;
      end
      md5_pkg::OP_INIT: begin
        chain_d[0] = md5_pkg::IV_A;
        chain_d[1] = md5_pkg::IV_B;
        chain_d[2] = md5_pkg::IV_C;
        chain_d[3] = md5_pkg::IV_D;
        count_d    = '0;
        pos_d      = '0;
        k_d        = '0;
      end
      default: ;
    endcase
    if (load_abcd) rnd_d = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q       <= md5_pkg::PC_WAIT;
      ret_q      <= md5_pkg::PC_WAIT;
      rnd_q      <= '0;
      pos_q      <= '0;
      k_q        <= '0;
      count_q    <= '0;
      chain_q[0] <= md5_pkg::IV_A;
      chain_q[1] <= md5_pkg::IV_B;
      chain_q[2] <= md5_pkg::IV_C;
      chain_q[3] <= md5_pkg::IV_D;
    end else begin
      pc_q    <= pc_d;
      ret_q   <= ret_d;
      rnd_q   <= rnd_d;
      pos_q   <= pos_d;
      k_q     <= k_d;
      count_q <= count_d;
      chain_q <= chain_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_abcd) begin
      a_q <= chain_q[0];
      b_q <= chain_q[1];
      c_q <= chain_q[2];
      d_q <= chain_q[3];
    end else if (cw.op == md5_pkg::OP_ROUND) begin
      a_q <= d_q;
      b_q <= b_q + rot;
      c_q <= b_q;
      d_q <= c_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_we) begin
      blk_q[pos_q[5:2]][{pos_q[1:0], 3'b000} +: 8] <= byte_wd;
    end else if (cw.op == md5_pkg::OP_LENLO) begin
      blk_q[md5_pkg::WORD_LENLO] <= count_q[31:0];
    end else if (cw.op == md5_pkg::OP_LENHI) begin
      blk_q[md5_pkg::WORD_LENHI] <= count_q[63:32];
    end
  end

endmodule
